[src/swlp_pkg.sv]
`default_nettype none
package swlp_pkg;

    localparam int TIME_BITS_DEFAULT = 32;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;
    localparam int IN_DATA_BITS   = 40;
    localparam int OUT_DATA_BITS  = 40;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_LIMIT = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RATE_SCALE = 8'd1;

    localparam logic [31:0] HOLD_LIMIT_RESET = 32'd10000;
    localparam logic [16:0] RATE_SCALE_RESET = 17'd65982;

    localparam logic [31:0] MS_PER_SEC = 32'd1000;
    localparam logic [22:0] SEC_PER_MIN = 23'd60;

    localparam logic [28:0] RECIP_1000 = 29'd274877907;
    localparam int          SHIFT_1000 = 38;
    localparam logic [22:0] RECIP_60   = 23'd4473925;
    localparam int          SHIFT_60   = 28;

    typedef struct packed {
        logic [9:0]  milliseconds;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [10:0] hours;
    } result_t;

endpackage
`default_nettype wire

[src/stopwatch_long_press_controller.sv]
// Result words leave the registered pipeline on m_tdata in input order.
// Throughput: one input word per cycle while the pipeline advances, which it
// does whenever the output register is empty or being taken.
// Only samples taken while the stopwatch runs produce a result word.
// Reset (aresetn low, synchronous): stopwatch stopped, times and press state
// cleared, hold limit 10000 ms, rate scale 65982 (Q1.16).
`default_nettype none
module stopwatch_long_press_controller #(
    parameter int TIME_BITS = swlp_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // now_ms [31:0], button_level [32], zero [39:33]
    input  wire logic [swlp_pkg::IN_DATA_BITS-1:0]   s_tdata,

    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // hours [10:0], minutes [16:11], seconds [22:17], milliseconds [32:23], zero [39:33]
    output logic [swlp_pkg::OUT_DATA_BITS-1:0]       m_tdata,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [swlp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [swlp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import swlp_pkg::*;

    logic [31:0]          hold_limit_reg;
    logic [16:0]          rate_scale_reg;

    logic                 running_reg;
    logic [TIME_BITS-1:0] start_time_reg;
    logic [TIME_BITS-1:0] press_start_reg;
    logic                 press_handled_reg;
    logic                 prev_level_reg;

    logic                 advance;
    logic                 accept;

    logic [TIME_BITS-1:0] now_t;
    logic                 level;
    logic                 press_edge;
    logic [TIME_BITS-1:0] press_start_eff;
    logic                 handled_eff;
    logic [TIME_BITS-1:0] held;
    logic                 stop;
    logic                 running_mid;
    logic                 start;
    logic [TIME_BITS-1:0] start_time_next;
    logic                 running_next;
    logic                 press_handled_next;
    logic [TIME_BITS-1:0] elapsed;
    logic [63:0]          elapsed_ext;

    // pipeline registers
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic [31:0] hi_reg;
    logic [15:0] lo_reg;
    logic        over_reg;
    logic [48:0] phi_reg;
    logic [16:0] plo_reg;
    logic        over2_reg;
    logic [31:0] ms_reg;
    logic [60:0] pk_reg;
    logic [31:0] ms4_reg;
    logic [22:0] st_reg;
    logic [9:0]  msr5_reg;
    logic [45:0] pm_reg;
    logic [22:0] st6_reg;
    logic [9:0]  msr6_reg;
    logic [16:0] tm_reg;
    logic [5:0]  sec7_reg;
    logic [9:0]  msr7_reg;
    logic [39:0] ph_reg;
    logic [16:0] tm8_reg;
    logic [5:0]  sec8_reg;
    logic [9:0]  msr8_reg;
    result_t     out_reg;

    logic [49:0] r_sum;
    logic [31:0] ms_next;
    logic        sat;
    logic [22:0] st_next;
    logic [31:0] st_x1000;
    logic [31:0] msr_full;
    logic [16:0] tm_next;
    logic [22:0] tm_x60;
    logic [22:0] sec_full;
    logic [10:0] hours_next;
    logic [16:0] hours_x60;
    logic [16:0] min_full;

    assign advance   = !v9_reg || m_tready;
    assign s_tready  = advance;
    assign accept    = s_tvalid && advance;
    assign cfg_ready = 1'b1;

    // sample decode and state update
    always_comb begin
        now_t              = TIME_BITS'(s_tdata[31:0]);
        level              = s_tdata[32];
        press_edge         = !level && prev_level_reg;
        press_start_eff    = press_edge ? now_t : press_start_reg;
        handled_eff        = press_edge ? 1'b0 : press_handled_reg;
        held               = now_t - press_start_eff;
        stop               = !level && !handled_eff && (64'(held) >= 64'(hold_limit_reg));
        running_mid        = stop ? 1'b0 : running_reg;
        press_handled_next = stop ? 1'b1 : handled_eff;
        start              = level && !running_mid;
        start_time_next    = start ? now_t : start_time_reg;
        running_next       = start ? 1'b1 : running_mid;
        elapsed            = now_t - start_time_next;
        elapsed_ext        = 64'(elapsed);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_limit_reg <= HOLD_LIMIT_RESET;
            rate_scale_reg <= RATE_SCALE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_HOLD_LIMIT) begin
                hold_limit_reg <= cfg_data[31:0];
            end else if (cfg_index == CFG_RATE_SCALE) begin
                rate_scale_reg <= cfg_data[16:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg       <= 1'b0;
            start_time_reg    <= '0;
            press_start_reg   <= '0;
            press_handled_reg <= 1'b0;
            prev_level_reg    <= 1'b0;
        end else if (accept) begin
            running_reg       <= running_next;
            start_time_reg    <= start_time_next;
            press_start_reg   <= press_start_eff;
            press_handled_reg <= press_handled_next;
            prev_level_reg    <= level;
        end
    end

    // scale, saturate and split
    always_comb begin
        r_sum      = 50'(phi_reg) + 50'(plo_reg);
        sat        = (over2_reg && (rate_scale_reg != '0)) || (r_sum[49:32] != '0);
        ms_next    = sat ? 32'hFFFF_FFFF : r_sum[31:0];
        st_next    = pk_reg[60:SHIFT_1000];
        st_x1000   = 32'(st_next) * MS_PER_SEC;
        msr_full   = ms4_reg - st_x1000;
        tm_next    = pm_reg[44:SHIFT_60];
        tm_x60     = 23'(tm_next) * SEC_PER_MIN;
        sec_full   = st6_reg - tm_x60;
        hours_next = ph_reg[38:SHIFT_60];
        hours_x60  = 17'(hours_next) * 17'(SEC_PER_MIN);
        min_full   = tm8_reg - hours_x60;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= accept && running_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hi_reg    <= elapsed_ext[47:16];
            lo_reg    <= elapsed_ext[15:0];
            over_reg  <= elapsed_ext[63:48] != '0;

            phi_reg   <= 49'(hi_reg) * 49'(rate_scale_reg);
            plo_reg   <= 17'((33'(lo_reg) * 33'(rate_scale_reg)) >> 16);
            over2_reg <= over_reg;

            ms_reg    <= ms_next;

            pk_reg    <= 61'(ms_reg) * 61'(RECIP_1000);
            ms4_reg   <= ms_reg;

            st_reg    <= st_next;
            msr5_reg  <= msr_full[9:0];

            pm_reg    <= 46'(st_reg) * 46'(RECIP_60);
            st6_reg   <= st_reg;
            msr6_reg  <= msr5_reg;

            tm_reg    <= tm_next;
            sec7_reg  <= sec_full[5:0];
            msr7_reg  <= msr6_reg;

            ph_reg    <= 40'(tm_reg) * 40'(RECIP_60);
            tm8_reg   <= tm_reg;
            sec8_reg  <= sec7_reg;
            msr8_reg  <= msr7_reg;

            out_reg.hours        <= hours_next;
            out_reg.minutes      <= min_full[5:0];
            out_reg.seconds      <= sec8_reg;
            out_reg.milliseconds <= msr8_reg;
        end
    end

    assign m_tvalid = v9_reg;
    assign m_tdata  = {7'd0, out_reg.milliseconds, out_reg.seconds,
                       out_reg.minutes, out_reg.hours};

endmodule
`default_nettype wire

[sim/stopwatch_long_press_controller_tb.sv]
`default_nettype none
module stopwatch_long_press_controller_tb;
    import swlp_pkg::*;

    localparam logic LVL_PRESSED  = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 8'd2;

    localparam int DUT_LATENCY    = 9;
    localparam int SETTLE_CYCLES  = 2 * DUT_LATENCY + 4;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_SAMPLES  = 325;

    typedef struct packed {
        logic        level;
        logic [31:0] now_ms;
    } sample_t;

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // predicted stopwatch state and settings
    logic        watch_running = 1'b0;
    logic [31:0] start_ms      = '0;
    logic [31:0] press_ms      = '0;
    logic        press_done    = 1'b0;
    logic        last_level    = 1'b0;
    logic [31:0] press_limit   = HOLD_LIMIT_RESET;
    logic [16:0] scale_q16     = RATE_SCALE_RESET;

    sample_t sample_q[$];
    result_t readout_q[$];
    sample_t offered;

    int samples_queued = 0;
    int samples_taken  = 0;
    int readouts_seen  = 0;
    int reg_writes     = 0;
    int n_fail         = 0;
    int tx_gap = 0, tx_calm = 0, rx_gap = 0, rx_calm = 0;
    logic rx_hold = 1'b0;
    logic [31:0] wall_ms = '0;

    stopwatch_long_press_controller i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #25_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic advance_watch(input sample_t smp);
        logic [31:0] held;
        logic [31:0] elapsed;
        logic [48:0] product;
        logic [31:0] total_ms;
        logic [31:0] total_s;
        result_t     r;
        if (!smp.level && last_level) begin
            press_ms   = smp.now_ms;
            press_done = 1'b0;
        end
        if (!smp.level && !press_done) begin
            held = smp.now_ms - press_ms;
            if (held >= press_limit) begin
                watch_running = 1'b0;
                press_done    = 1'b1;
            end
        end
        if (smp.level && !watch_running) begin
            start_ms      = smp.now_ms;
            watch_running = 1'b1;
        end
        last_level = smp.level;
        if (watch_running) begin
            elapsed        = smp.now_ms - start_ms;
            product        = elapsed * scale_q16;
            total_ms       = product[48] ? 32'hFFFF_FFFF : product[47:16];
            total_s        = total_ms / 1000;
            r.hours        = 11'(total_s / 3600);
            r.minutes      = 6'((total_s % 3600) / 60);
            r.seconds      = 6'(total_s % 60);
            r.milliseconds = 10'(total_ms % 1000);
            readout_q.push_back(r);
        end
    endtask

    task automatic next_gap(inout int calm, output int gap);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else begin
            if (r < 55) gap = 0;
            else if (r < 85) gap = $urandom_range(1, 3);
            else if (r < 97) gap = $urandom_range(4, 15);
            else gap = $urandom_range(30, 120);
            if ($urandom_range(0, 39) == 0) calm = $urandom_range(20, 150);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_watch(offered);
                samples_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    offered = sample_q.pop_front();
                    s_tdata  <= {{(IN_DATA_BITS - $bits(sample_t)){1'b0}}, offered};
                    s_tvalid <= 1'b1;
                    next_gap(tx_calm, tx_gap);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(result_t)-1:0];
                readouts_seen++;
                if (readout_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected word: %0d:%0d:%0d.%0d", got.hours, got.minutes,
                                 got.seconds, got.milliseconds);
                end else begin
                    want = readout_q.pop_front();
                    if (got.hours !== want.hours || got.minutes !== want.minutes ||
                        got.seconds !== want.seconds ||
                        got.milliseconds !== want.milliseconds) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("mismatch: expected %0d:%0d:%0d.%0d, got %0d:%0d:%0d.%0d",
                                     want.hours, want.minutes, want.seconds,
                                     want.milliseconds, got.hours, got.minutes,
                                     got.seconds, got.milliseconds);
                    end
                end
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready) next_gap(rx_calm, rx_gap);
            end
        end
    end

    // hold the output side while the driver keeps offering input words
    initial begin
        wait (samples_taken >= 700);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    task automatic add_sample(input logic [31:0] t, input logic lvl);
        sample_t smp;
        smp.now_ms = t;
        smp.level  = lvl;
        sample_q.push_back(smp);
        samples_queued++;
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while ((samples_queued != samples_taken || readout_q.size() != 0) && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        if (samples_queued != samples_taken) begin
            n_fail++;
            $display("%0d input words never accepted", samples_queued - samples_taken);
        end
        if (readout_q.size() != 0) begin
            n_fail += readout_q.size();
            $display("%0d expected words never arrived", readout_q.size());
            readout_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HOLD_LIMIT: press_limit = val;
            CFG_RATE_SCALE: scale_q16 = val[16:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic random_burst(input int count);
        int          press_left;
        int          r;
        logic        lvl;
        logic [31:0] step_max;
        press_left = 0;
        step_max   = (press_limit > 30000) ? 32'd10000 : press_limit / 3 + 1;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60) wall_ms += $urandom_range(0, step_max);
            else if (r < 88) wall_ms += $urandom_range(0, 100);
            else if (r < 97) wall_ms += $urandom();
            else wall_ms = $urandom();
            if (press_left > 0) begin
                press_left--;
                lvl = LVL_PRESSED;
            end else if ($urandom_range(0, 99) < 15) begin
                press_left = $urandom_range(0, 12);
                lvl = LVL_PRESSED;
            end else begin
                lvl = LVL_RELEASED;
            end
            // flip the odd sample
            if ($urandom_range(0, 99) < 4) lvl = ~lvl;
            add_sample(wall_ms, lvl);
        end
    endtask

    initial begin
        logic [31:0] hl;
        logic [16:0] rs;
        logic [14:0] junk;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_sample(32'd5000, LVL_PRESSED);
        add_sample(32'd10000, LVL_PRESSED);
        add_sample(32'd20000, LVL_RELEASED);
        add_sample(32'd20001, LVL_RELEASED);
        add_sample(32'd19999, LVL_RELEASED);
        add_sample(32'd30000, LVL_PRESSED);
        add_sample(32'd39999, LVL_PRESSED);
        add_sample(32'd40000, LVL_PRESSED);
        add_sample(32'd50000, LVL_PRESSED);
        add_sample(32'd60000, LVL_RELEASED);
        add_sample(32'd60000 + 32'd123456789, LVL_RELEASED);
        drain();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        write_reg(CFG_HOLD_LIMIT, 32'd0);
        write_reg(CFG_RATE_SCALE, 32'd65536);
        add_sample(32'd100, LVL_PRESSED);
        add_sample(32'hFFFF_FFF0, LVL_RELEASED);
        add_sample(32'h0000_000F, LVL_RELEASED);
        add_sample(32'hFFFF_FFF0 + 32'd3599999, LVL_RELEASED);
        add_sample(32'hFFFF_FFEF, LVL_RELEASED);
        add_sample(32'd7, LVL_PRESSED);
        drain();
        write_reg(CFG_HOLD_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_RATE_SCALE, 32'd0);
        add_sample(32'd500, LVL_RELEASED);
        add_sample(32'd1000, LVL_RELEASED);
        add_sample(32'd2000, LVL_PRESSED);
        add_sample(32'd1999, LVL_PRESSED);
        add_sample(32'd3000, LVL_RELEASED);
        drain();
        write_reg(CFG_HOLD_LIMIT, HOLD_LIMIT_RESET);
        write_reg(CFG_RATE_SCALE, 32'h0001_FFFF);
        add_sample(32'd4000, LVL_RELEASED);
        add_sample(32'd2999, LVL_RELEASED);
        add_sample(32'd3049, LVL_PRESSED);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    hl = HOLD_LIMIT_RESET;
                    rs = RATE_SCALE_RESET;
                end
                1: begin
                    hl = 32'd0;
                    rs = 17'h1FFFF;
                end
                2: begin
                    hl = 32'hFFFF_FFFF;
                    rs = 17'd0;
                end
                3: begin
                    hl = $urandom_range(1, 3000);
                    rs = 17'($urandom_range(0, 131071));
                end
                4: begin
                    hl = $urandom();
                    rs = 17'd65536;
                end
                default: begin
                    hl = $urandom_range(500, 20000);
                    rs = 17'($urandom_range(60000, 70000));
                end
            endcase
            junk = 15'($urandom_range(0, 32767));
            drain();
            write_reg(CFG_RATE_SCALE, {junk, rs});
            write_reg(CFG_HOLD_LIMIT, hl);
            random_burst(PHASE_SAMPLES);
        end
        drain();

        $display("Run covered %0d samples, %0d time words checked, %0d register writes.",
                 samples_taken, readouts_seen, reg_writes);
        $display("Settings spanned zero and full-scale hold limits and scale factors 0 to 2.0.");
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
